/* design/rsb_pkg.sv */
// Shared types and codes for the run-length sprite line blitter.
package rsb_pkg;

  // input item operations
  localparam logic [1:0] OpPalette = 2'd0;
  localparam logic [1:0] OpBegin   = 2'd1;
  localparam logic [1:0] OpCode    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegStartX     = 3'd0;
  localparam logic [2:0] RegStartY     = 3'd1;
  localparam logic [2:0] RegClipLeft   = 3'd2;
  localparam logic [2:0] RegClipRight  = 3'd3;
  localparam logic [2:0] RegClipTop    = 3'd4;
  localparam logic [2:0] RegClipBottom = 3'd5;
  localparam logic [2:0] RegMirror     = 3'd6;

  localparam int unsigned CfgAddrWidth = 5;

  localparam logic [7:0] RowEndCode = 8'hFF;

  // command queue between parser and palette stage
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrWidth   = 2;
  localparam int unsigned CntWidth   = 3;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [12:0]        clip_left;
    logic [12:0]        clip_right;
    logic [12:0]        clip_top;
    logic [12:0]        clip_bottom;
    logic               mirror;
  } cfg_t;

  // one queued command: palette write or visible pixel
  typedef struct packed {
    logic        is_write;
    logic        idx_ok;
    logic [7:0]  index;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
  } cmd_t;

endpackage

/* design/rsb_front.sv */
// Stream parser: tracks row, cursor and run state and emits commands.
module rsb_front #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned SCREEN_SPAN     = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [1:0]    op_i,
  input  logic          row_start_i,
  input  logic [7:0]    code_byte_i,
  input  logic [7:0]    palette_index_i,
  input  logic [31:0]   palette_color_i,
  input  rsb_pkg::cfg_t cfg_i,
  output logic          push_o,
  output rsb_pkg::cmd_t cmd_o
);

  localparam logic [1:0] PhaseSkip = 2'd0;
  localparam logic [1:0] PhaseRun  = 2'd1;
  localparam logic [1:0] PhasePix  = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [7:0]         run_q, run_d;
  logic signed [17:0] cur_q, cur_d;
  logic signed [16:0] row_q, row_d;
  logic               ended_q, ended_d;

  logic               rs;
  logic signed [17:0] sx_ext, cur_rs, byte_ext, cur_step, px, cur_pix;
  logic signed [17:0] cl_ext, cr_ext;
  logic signed [16:0] ct_ext, cb_ext, row_rs;
  logic               ended_rs;
  logic [1:0]         phase_rs;
  logic [7:0]         run_rs, run_dec;
  logic               out_now, out_step, show;

  assign rs       = (op_i == rsb_pkg::OpCode) && row_start_i;
  assign sx_ext   = {{2{cfg_i.start_x[15]}}, cfg_i.start_x};
  assign byte_ext = {10'b0, code_byte_i};
  assign cl_ext   = {5'b0, cfg_i.clip_left};
  assign cr_ext   = {5'b0, cfg_i.clip_right};
  assign ct_ext   = {4'b0, cfg_i.clip_top};
  assign cb_ext   = {4'b0, cfg_i.clip_bottom};

  // a row-start byte first restarts the row, then parses as a skip count
  assign cur_rs   = rs ? sx_ext : cur_q;
  assign row_rs   = rs ? row_q + 17'sd1 : row_q;
  assign ended_rs = rs ? 1'b0 : ended_q;
  assign phase_rs = rs ? PhaseSkip : phase_q;
  assign run_rs   = rs ? 8'd0 : run_q;

  assign cur_step = cfg_i.mirror ? cur_rs - byte_ext : cur_rs + byte_ext;
  assign out_now  = cfg_i.mirror ? (cur_rs <= cl_ext) : (cur_rs >= cr_ext);
  assign out_step = cfg_i.mirror ? (cur_step <= cl_ext) : (cur_step >= cr_ext);

  // mirror: pixel lands one left of the cursor
  assign px      = cfg_i.mirror ? cur_rs - 18'sd1 : cur_rs;
  assign cur_pix = cfg_i.mirror ? cur_rs - 18'sd1 : cur_rs + 18'sd1;
  assign run_dec = run_rs - 8'd1;

  assign show = (px >= cl_ext) && (px < cr_ext) && ($unsigned(px) < 18'(SCREEN_SPAN)) &&
                (row_rs >= ct_ext) && (row_rs < cb_ext) &&
                ($unsigned(row_rs) < 17'(SCREEN_SPAN));

  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    cur_d   = cur_q;
    row_d   = row_q;
    ended_d = ended_q;
    push_o  = 1'b0;

    cmd_o.is_write = (op_i == rsb_pkg::OpPalette);
    cmd_o.idx_ok   = (op_i == rsb_pkg::OpPalette) ?
                     ({1'b0, palette_index_i} < 9'(PALETTE_ENTRIES)) :
                     ({1'b0, code_byte_i} < 9'(PALETTE_ENTRIES));
    cmd_o.index    = (op_i == rsb_pkg::OpPalette) ? palette_index_i : code_byte_i;
    cmd_o.x        = px[11:0];
    cmd_o.y        = row_rs[11:0];
    cmd_o.color    = palette_color_i;

    if (take_i) begin
      unique case (op_i)
        rsb_pkg::OpPalette: begin
          push_o = cmd_o.idx_ok;
        end
        rsb_pkg::OpBegin: begin
          row_d   = {cfg_i.start_y[15], cfg_i.start_y} - 17'sd1;
          cur_d   = sx_ext;
          ended_d = 1'b1;
          phase_d = PhaseSkip;
          run_d   = 8'd0;
        end
        rsb_pkg::OpCode: begin
          row_d   = row_rs;
          cur_d   = cur_rs;
          ended_d = ended_rs;
          phase_d = phase_rs;
          run_d   = run_rs;
          if (!ended_rs) begin
            unique case (phase_rs)
              PhaseSkip: begin
                if (out_now || code_byte_i == rsb_pkg::RowEndCode) begin
                  ended_d = 1'b1;
                end else begin
                  cur_d = cur_step;
                  if (out_step) begin
                    ended_d = 1'b1;
                  end else begin
                    phase_d = PhaseRun;
                  end
                end
              end
              PhaseRun: begin
                if (code_byte_i == 8'd0) begin
                  phase_d = PhaseSkip;
                end else begin
                  run_d   = code_byte_i;
                  phase_d = PhasePix;
                end
              end
              PhasePix: begin
                cur_d  = cur_pix;
                run_d  = run_dec;
                push_o = show;
                if (run_dec == 8'd0) begin
                  phase_d = PhaseSkip;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseSkip;
      run_q   <= 8'd0;
      cur_q   <= 18'sd0;
      row_q   <= 17'sd0;
      ended_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      cur_q   <= cur_d;
      row_q   <= row_d;
      ended_q <= ended_d;
    end
  end

endmodule

/* design/rsb_queue.sv */
// Short command FIFO between the parser and the palette stage.
module rsb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsb_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output rsb_pkg::cmd_t head_o,
  input  logic          pop_i
);

  rsb_pkg::cmd_t                   entries_q [rsb_pkg::QueueDepth];
  logic [rsb_pkg::PtrWidth-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rsb_pkg::CntWidth-1:0]    count_q;

  assign full_o       = (count_q == rsb_pkg::CntWidth'(rsb_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/rsb_back.sv */
// Palette memory and output register: executes queued writes and pixel lookups.
module rsb_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  rsb_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [11:0]   pixel_x_o,
  output logic [11:0]   pixel_y_o,
  output logic [31:0]   pixel_color_o
);

  localparam int unsigned IdxWidth = $clog2(PALETTE_ENTRIES);

  logic [31:0]         palette_mem [PALETTE_ENTRIES];
  logic [31:0]         rdata_q;
  logic [IdxWidth-1:0] addr;
  logic                pix_take, wr_en, rd_en;
  logic                out_valid_q, ok_q;
  logic [11:0]         x_q, y_q;

  assign addr     = head_i.index[IdxWidth-1:0];
  assign pix_take = head_valid_i && !head_i.is_write && (!out_valid_q || !out_stall_i);
  assign wr_en    = head_valid_i && head_i.is_write && head_i.idx_ok;
  assign rd_en    = pix_take && head_i.idx_ok;
  // writes never wait; a pixel waits for a free output slot
  assign pop_o    = (head_valid_i && head_i.is_write) || pix_take;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      palette_mem[addr] <= head_i.color;
    end
    if (rd_en) begin
      rdata_q <= palette_mem[addr];
    end
    if (pix_take) begin
      x_q  <= head_i.x;
      y_q  <= head_i.y;
      ok_q <= head_i.idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign pixel_color_o = ok_q ? rdata_q : 32'd0;

endmodule

/* design/rle_sprite_line_blitter_unit.sv */
// Top level of the run-length sprite line blitter: config registers and datapath.
//
// Input channel (in_valid_i / in_stall_o) takes one word per cycle while
// in_stall_o is low: a palette write, a begin-sprite marker or one sprite code
// byte. The parser updates its row, cursor and run state in the cycle the word
// is taken and queues a command only for a palette write or a visible pixel.
// Output channel (out_valid_o / out_stall_i) carries one pixel word: screen
// column, row and palette color. Clipped pixels and non-pixel words give no
// output.
// With an empty queue a pixel word passes through the queue write and then the
// output register before it is presented.
// Throughput: one input word per cycle, sustained, while the receiver takes
// pixels; the 4-entry command queue plus output register absorb short stalls.
// When the receiver stalls, the output word holds, the queue fills, and once
// it holds 4 commands in_stall_o rises until the output drains.
// Configuration goes through the APB port (byte address 4*index); the user must
// write it only while the block is idle, which the block does not enforce. Reset
// clears the parser to "row ended", empties the queue and the output register and
// loads the register defaults; the palette holds garbage until written.
module rle_sprite_line_blitter_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned SCREEN_SPAN     = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsb_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic                             row_start_i,
  input  logic [7:0]                       code_byte_i,
  input  logic [7:0]                       palette_index_i,
  input  logic [31:0]                      palette_color_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [11:0]                      pixel_x_o,
  output logic [11:0]                      pixel_y_o,
  output logic [31:0]                      pixel_color_o
);

  rsb_pkg::cfg_t cfg_q;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  logic          q_full, take, push, head_valid, pop;
  rsb_pkg::cmd_t cmd, head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x     <= 16'sd0;
      cfg_q.start_y     <= 16'sd0;
      cfg_q.clip_left   <= 13'd0;
      cfg_q.clip_right  <= 13'd4096;
      cfg_q.clip_top    <= 13'd0;
      cfg_q.clip_bottom <= 13'd4096;
      cfg_q.mirror      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rsb_pkg::RegStartX:     cfg_q.start_x     <= pwdata[15:0];
        rsb_pkg::RegStartY:     cfg_q.start_y     <= pwdata[15:0];
        rsb_pkg::RegClipLeft:   cfg_q.clip_left   <= pwdata[12:0];
        rsb_pkg::RegClipRight:  cfg_q.clip_right  <= pwdata[12:0];
        rsb_pkg::RegClipTop:    cfg_q.clip_top    <= pwdata[12:0];
        rsb_pkg::RegClipBottom: cfg_q.clip_bottom <= pwdata[12:0];
        rsb_pkg::RegMirror:     cfg_q.mirror      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rsb_pkg::RegStartX:     prdata = {16'd0, cfg_q.start_x};
      rsb_pkg::RegStartY:     prdata = {16'd0, cfg_q.start_y};
      rsb_pkg::RegClipLeft:   prdata = {19'd0, cfg_q.clip_left};
      rsb_pkg::RegClipRight:  prdata = {19'd0, cfg_q.clip_right};
      rsb_pkg::RegClipTop:    prdata = {19'd0, cfg_q.clip_top};
      rsb_pkg::RegClipBottom: prdata = {19'd0, cfg_q.clip_bottom};
      rsb_pkg::RegMirror:     prdata = {31'd0, cfg_q.mirror};
      default:                prdata = 32'd0;
    endcase
  end

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  rsb_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .SCREEN_SPAN    (SCREEN_SPAN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .op_i           (op_i),
    .row_start_i    (row_start_i),
    .code_byte_i    (code_byte_i),
    .palette_index_i(palette_index_i),
    .palette_color_i(palette_color_i),
    .cfg_i          (cfg_q),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  rsb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  rsb_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o)
  );

endmodule

/* design/rsb_checker.sv */
// Port-level checks for the blitter, bound to the top level.
module rsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] pixel_x_o,
  input logic [11:0] pixel_y_o,
  input logic [31:0] pixel_color_o
);

  // stalled pixel word stays presented
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  // stalled pixel word keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_x_o) && $stable(pixel_y_o) &&
                                   $stable(pixel_color_o))
    else $error("pixel payload changed while stalled");

  // output register comes out of reset empty
  a_reset_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("pixel word presented right after reset");

  // input back-pressure only arises from a stalled output
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind rle_sprite_line_blitter_unit rsb_checker u_rsb_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the run-length sprite line blitter unit.
module testbench;

  localparam int          ScreenSpan = 4096;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseWords = 45;
  localparam int unsigned NumSettings = 9;
  localparam logic [1:0]  OpUnused = 2'd3;

  typedef enum logic [1:0] {ExpectSkip, ExpectRun, ExpectPixel} parse_e;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
  } pix_t;

  localparam pix_t NoPix = '0;

  // one row of the directed table: a register write or an input word
  typedef struct {
    bit          is_cfg;
    logic [2:0]  cfg_reg;
    logic [31:0] value;
    logic [1:0]  op;
    logic        rs;
    logic [7:0]  code;
    logic [7:0]  pidx;
    logic [31:0] pcol;
    bit          typed;
    pix_t        want;
  } step_t;

  typedef struct {
    int sx, sy, cl, cr, ct, cb;
    bit mir;
  } setting_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [rsb_pkg::CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [1:0]                       op_i = rsb_pkg::OpCode;
  logic                             row_start_i = 1'b0;
  logic [7:0]                       code_byte_i = '0;
  logic [7:0]                       palette_index_i = '0;
  logic [31:0]                      palette_color_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [11:0]                      pixel_x_o;
  logic [11:0]                      pixel_y_o;
  logic [31:0]                      pixel_color_o;

  rle_sprite_line_blitter_unit #(
    .PALETTE_ENTRIES(256),
    .SCREEN_SPAN    (ScreenSpan)
  ) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .row_start_i, .code_byte_i, .palette_index_i,
    .palette_color_i, .out_valid_o, .out_stall_i, .pixel_x_o, .pixel_y_o, .pixel_color_o
  );

  always #1 clk_i = ~clk_i;

  // blitter state as seen by the checker
  rsb_pkg::cfg_t      cfg;
  logic [31:0]        palette [256];
  parse_e             parse_state;
  logic [7:0]         run_left;
  logic signed [17:0] cur_x;
  logic signed [16:0] row_y;
  bit                 row_done;
  pix_t               pending_pixels[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned phase_start;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_seen = 1'b0;
  bit          long_hold_on = 1'b0;
  pix_t        head_pix;

  step_t directed_steps[28] = '{
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h05, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpPalette, 1'b0, 8'h00, 8'h00,
      32'hFFFF_FFFF, 1'b0, NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpPalette, 1'b1, 8'hFF, 8'hFF,
      32'h0000_0000, 1'b0, NoPix},
    // row before any begin: counts up from row 0
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b1, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h02, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b1,
      '{12'd0, 12'd1, 32'hFFFF_FFFF}},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'hFF, 8'h00, 32'h0, 1'b1,
      '{12'd1, 12'd1, 32'h0000_0000}},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    // zero run, then row end, then a stray byte
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, rsb_pkg::RowEndCode, 8'h00,
      32'h0, 1'b0, NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h07, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, OpUnused, 1'b1, 8'hAA, 8'h55, 32'hDEAD_BEEF, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpBegin, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b1, 8'hFE, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h01, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'hFF, 8'h00, 32'h0, 1'b1,
      '{12'd254, 12'd0, 32'h0000_0000}},
    // mirrored, first pixel lands off screen at column 4096
    '{1'b1, rsb_pkg::RegStartX, 32'd4097, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b1, rsb_pkg::RegMirror, 32'd1, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpBegin, 1'b1, 8'hFF, 8'hFF, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b1, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h02, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b1,
      '{12'd4095, 12'd0, 32'hFFFF_FFFF}},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b1, 8'hFA, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'hFF, 8'h00, 32'h0, 1'b0,
      NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix},
    // new row abandons the long run and ends at once
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b1, rsb_pkg::RowEndCode, 8'h00,
      32'h0, 1'b0, NoPix},
    '{1'b0, rsb_pkg::RegStartX, 32'd0, rsb_pkg::OpCode, 1'b0, 8'h00, 8'h00, 32'h0, 1'b0,
      NoPix}
  };

  setting_t settings[NumSettings] = '{
    '{0, 0, 0, 4096, 0, 4096, 1'b0},
    '{100, 50, 120, 300, 52, 70, 1'b0},
    '{300, -3, 0, 4096, 0, 4096, 1'b1},
    '{-32768, 32767, 0, 4096, 0, 4096, 1'b0},
    '{4000, 4090, 0, 4096, 0, 4096, 1'b0},
    '{32767, -32768, 4096, 0, 0, 4096, 1'b1},
    '{10, 0, 200, 100, 4096, 0, 1'b0},
    '{4095, 20, 3900, 4096, 0, 4096, 1'b1},
    '{0, 0, 0, 4096, 0, 4096, 1'b0}
  };

  function automatic bit past_edge();
    return cfg.mirror ? (int'(cur_x) <= int'(cfg.clip_left))
                      : (int'(cur_x) >= int'(cfg.clip_right));
  endfunction

  // advance the blitter state by one word; returns 1 when a pixel is drawn
  function automatic bit blit_word(input logic [1:0] op, input logic rs,
                                   input logic [7:0] code, input logic [7:0] pidx,
                                   input logic [31:0] pcol, output pix_t pix);
    int px;
    int py;
    pix = '0;
    if (op == rsb_pkg::OpPalette) begin
      palette[pidx] = pcol;
      return 1'b0;
    end
    if (op == rsb_pkg::OpBegin) begin
      row_y = $signed(cfg.start_y);
      row_y = row_y - 17'sd1;
      cur_x = $signed(cfg.start_x);
      row_done = 1'b1;
      parse_state = ExpectSkip;
      run_left = '0;
      return 1'b0;
    end
    if (op != rsb_pkg::OpCode) return 1'b0;
    if (rs) begin
      row_y = row_y + 17'sd1;
      cur_x = $signed(cfg.start_x);
      row_done = 1'b0;
      parse_state = ExpectSkip;
      run_left = '0;
    end
    if (row_done) return 1'b0;
    case (parse_state)
      ExpectSkip: begin
        if (past_edge() || code == rsb_pkg::RowEndCode) begin
          row_done = 1'b1;
          return 1'b0;
        end
        if (cfg.mirror) cur_x = cur_x - 18'(code);
        else cur_x = cur_x + 18'(code);
        // nothing more can be visible once the cursor is past the clip edge
        if (past_edge()) row_done = 1'b1;
        else parse_state = ExpectRun;
        return 1'b0;
      end
      ExpectRun: begin
        if (code == 8'd0) begin
          parse_state = ExpectSkip;
        end else begin
          run_left = code;
          parse_state = ExpectPixel;
        end
        return 1'b0;
      end
      default: ;
    endcase
    if (cfg.mirror) begin
      cur_x = cur_x - 18'sd1;
      px = cur_x;
    end else begin
      px = cur_x;
      cur_x = cur_x + 18'sd1;
    end
    run_left = run_left - 8'd1;
    if (run_left == 8'd0) parse_state = ExpectSkip;
    py = row_y;
    if (px < int'(cfg.clip_left) || px >= int'(cfg.clip_right) || px < 0 ||
        px >= ScreenSpan || py < int'(cfg.clip_top) || py >= int'(cfg.clip_bottom) ||
        py < 0 || py >= ScreenSpan)
      return 1'b0;
    pix.x = px[11:0];
    pix.y = py[11:0];
    pix.color = palette[code];
    return 1'b1;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rsb_pkg::RegStartX:     cfg.start_x = data[15:0];
      rsb_pkg::RegStartY:     cfg.start_y = data[15:0];
      rsb_pkg::RegClipLeft:   cfg.clip_left = data[12:0];
      rsb_pkg::RegClipRight:  cfg.clip_right = data[12:0];
      rsb_pkg::RegClipTop:    cfg.clip_top = data[12:0];
      rsb_pkg::RegClipBottom: cfg.clip_bottom = data[12:0];
      rsb_pkg::RegMirror:     cfg.mirror = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    apb_write(rsb_pkg::RegStartX, {16'd0, 16'(s.sx)});
    apb_write(rsb_pkg::RegStartY, {16'd0, 16'(s.sy)});
    apb_write(rsb_pkg::RegClipLeft, {19'd0, 13'(s.cl)});
    apb_write(rsb_pkg::RegClipRight, {19'd0, 13'(s.cr)});
    apb_write(rsb_pkg::RegClipTop, {19'd0, 13'(s.ct)});
    apb_write(rsb_pkg::RegClipBottom, {19'd0, 13'(s.cb)});
    apb_write(rsb_pkg::RegMirror, {31'd0, s.mir});
  endtask

  // called from a process synchronised to clk_i; returns once the blitter has taken the word
  task automatic send_word(input logic [1:0] op, input logic rs, input logic [7:0] code,
                           input logic [7:0] pidx, input logic [31:0] pcol,
                           input bit typed, input pix_t want);
    pix_t got;
    bit   hit;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    row_start_i <= rs;
    code_byte_i <= code;
    palette_index_i <= pidx;
    palette_color_i <= pcol;
    do @(posedge clk_i); while (in_stall_o);
    hit = blit_word(op, rs, code, pidx, pcol, got);
    if (typed) pending_pixels.push_back(want);
    else if (hit) pending_pixels.push_back(got);
    words_sent++;
  endtask

  task automatic code_word(input logic rs, input logic [7:0] code);
    send_word(rsb_pkg::OpCode, rs, code, 8'($urandom()), $urandom(), 1'b0, NoPix);
  endtask

  task automatic noise_word();
    case ($urandom_range(3))
      0: send_word(OpUnused, 1'($urandom()), 8'($urandom()), 8'($urandom()), $urandom(),
                   1'b0, NoPix);
      1: code_word(1'($urandom()), 8'($urandom()));
      2: send_word(rsb_pkg::OpPalette, 1'($urandom()), 8'($urandom()), 8'($urandom()),
                   $urandom(), 1'b0, NoPix);
      default: send_word(rsb_pkg::OpBegin, 1'($urandom()), 8'($urandom()), 8'($urandom()),
                         $urandom(), 1'b0, NoPix);
    endcase
  endtask

  function automatic logic [7:0] pick_skip();
    int unsigned r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(20));
    if (r < 90) return 8'($urandom_range(100, 21));
    if (r < 98) return 8'($urandom_range(254, 101));
    return rsb_pkg::RowEndCode;
  endfunction

  function automatic int pick_run();
    int unsigned r = $urandom_range(99);
    if ($urandom_range(399) == 0) return 255;
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(8, 1);
    return $urandom_range(40, 9);
  endfunction

  task automatic emit_row();
    int pairs;
    int run;
    pairs = $urandom_range(4, 1);
    code_word(1'b1, pick_skip());
    for (int p = 0; p < pairs; p++) begin
      run = pick_run();
      code_word(1'b0, 8'(run));
      for (int i = 0; i < run; i++) begin
        if ($urandom_range(199) == 0) return;  // row cut short mid-run
        if ($urandom_range(99) < 2) noise_word();
        code_word(1'b0, 8'($urandom()));
      end
      if (p < pairs - 1) code_word(1'b0, pick_skip());
      else if ($urandom_range(9) != 0) code_word(1'b0, rsb_pkg::RowEndCode);
    end
  endtask

  task automatic emit_sprite();
    int rows;
    rows = $urandom_range(5, 1);
    send_word(rsb_pkg::OpBegin, 1'($urandom()), 8'($urandom()), 8'($urandom()), $urandom(),
              1'b0, NoPix);
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(9) == 0) noise_word();
      emit_row();
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    // palette writes may still sit in the queue
    repeat (8) @(posedge clk_i);
  endtask

  // pixel receiver: random stall, one long hold-off, and the checks
  always @(posedge clk_i) begin
    if (long_hold_on && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel word with none pending: x %0d y %0d color %08h",
               pixel_x_o, pixel_y_o, pixel_color_o);
        error_count++;
      end else begin
        head_pix = pending_pixels.pop_front();
        if (pixel_x_o !== head_pix.x) begin
          $error("pixel_x: expected %0d, got %0d", head_pix.x, pixel_x_o);
          error_count++;
        end
        if (pixel_y_o !== head_pix.y) begin
          $error("pixel_y: expected %0d, got %0d", head_pix.y, pixel_y_o);
          error_count++;
        end
        if (pixel_color_o !== head_pix.color) begin
          $error("pixel_color: expected %08h, got %08h", head_pix.color, pixel_color_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg = '0;
    cfg.clip_right = 13'd4096;
    cfg.clip_bottom = 13'd4096;
    parse_state = ExpectSkip;
    run_left = '0;
    cur_x = '0;
    row_y = '0;
    row_done = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_idle();
        apb_write(directed_steps[i].cfg_reg, directed_steps[i].value);
      end else begin
        send_word(directed_steps[i].op, directed_steps[i].rs, directed_steps[i].code,
                  directed_steps[i].pidx, directed_steps[i].pcol, directed_steps[i].typed,
                  directed_steps[i].want);
      end
    end

    for (int k = 0; k < NumSettings; k++) begin
      wait_idle();
      apply_setting(settings[k]);
      case (k % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 70;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 70;
        end
        default: begin
          sender_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      // whole palette is written before any random sprite pixel can look it up
      if (k == 0) begin
        for (int i = 0; i < 256; i++)
          send_word(rsb_pkg::OpPalette, 1'($urandom()), 8'($urandom()), 8'(i), $urandom(),
                    1'b0, NoPix);
      end
      // receiver holds off while the sender keeps pushing
      if (k == NumSettings - 1) long_hold_on = 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) emit_sprite();
    end

    wait_idle();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
